// ===== design/hbd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hbd_pkg
// Shared types and constants for the Hamming block decoder.
// ----------------------------------------------------------------------------
package hbd_pkg;

    // Largest supported parity count and width of the order register
    localparam int MAX_ORDER_DEF = 6;
    localparam int ORDER_W       = 3;
    localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd3;
    localparam logic [ORDER_W-1:0] ORDER_MIN   = 3'd2;

    // Controller states
    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_READ,
        ST_SHOW
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // input transfer this cycle
        logic rd_en;    // read store at current data index
        logic advance;  // step to the next data index
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic complete; // the bit on the input finishes a codeword
        logic last;     // current data index is the final one of the word
    } t_status;

endpackage
`default_nettype wire

// ===== design/hbd_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hbd_in_if
// Code bit channel: valid/ready handshake with one received bit per transfer.
// ----------------------------------------------------------------------------
interface hbd_in_if;
    logic valid;
    logic ready;
    logic code_bit;
    logic stream_end;

    modport source (output valid, output code_bit, output stream_end, input ready);
    modport sink   (input valid, input code_bit, input stream_end, output ready);
endinterface
`default_nettype wire

// ===== design/hbd_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hbd_out_if
// Data bit channel: valid/ready handshake with one corrected bit per transfer.
// ----------------------------------------------------------------------------
interface hbd_out_if;
    logic valid;
    logic ready;
    logic data_bit;
    logic block_last;

    modport source (output valid, output data_bit, output block_last, input ready);
    modport sink   (input valid, input data_bit, input block_last, output ready);
endinterface
`default_nettype wire

// ===== design/hbd_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hbd_ctrl
// Sequencer: collects a codeword, then walks the data positions, with a read
// state and an output state for each data bit.
// ----------------------------------------------------------------------------
module hbd_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_out_ready,
    input  wire hbd_pkg::t_status i_status,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    output hbd_pkg::t_cmd        o_cmd
);

    hbd_pkg::t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hbd_pkg::ST_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        o_cmd         = '0;
        case (r_state)
            hbd_pkg::ST_COLLECT: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                if (i_in_valid && i_status.complete) begin
                    n_state = hbd_pkg::ST_READ;
                end
            end
            hbd_pkg::ST_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = hbd_pkg::ST_SHOW;
            end
            hbd_pkg::ST_SHOW: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_status.last) begin
                        n_state = hbd_pkg::ST_COLLECT;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state       = hbd_pkg::ST_READ;
                    end
                end
            end
            default: begin
                n_state = hbd_pkg::ST_COLLECT;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== design/hbd_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hbd_dpath
// Codeword store, syndrome accumulator, position counters and order register.
// ----------------------------------------------------------------------------
module hbd_dpath #(
    parameter int MAX_ORDER = hbd_pkg::MAX_ORDER_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [hbd_pkg::ORDER_W-1:0] i_cfg_wdata,
    input  wire hbd_pkg::t_cmd               i_cmd,
    input  wire logic                        i_code_bit,
    input  wire logic                        i_stream_end,
    output hbd_pkg::t_status                 o_status,
    output logic                             o_data_bit,
    output logic                             o_block_last
);

    localparam int POS_W = MAX_ORDER;
    localparam int DEPTH = (1 << MAX_ORDER) - 1;
    localparam logic [hbd_pkg::ORDER_W-1:0] ORDER_MAX = hbd_pkg::ORDER_W'(MAX_ORDER);
    localparam logic [POS_W-1:0] ALL_ONES  = {POS_W{1'b1}};
    localparam logic [POS_W-1:0] FIRST_IDX = POS_W'(2);

    logic [hbd_pkg::ORDER_W-1:0] r_order;
    logic [POS_W-1:0]            r_pos;
    logic [POS_W-1:0]            r_syn;
    logic [POS_W-1:0]            r_fill;
    logic [POS_W-1:0]            r_len_m1;
    logic [POS_W-1:0]            r_flip;
    logic [POS_W-1:0]            r_idx;
    logic                        r_rd;
    logic                        mem [DEPTH];

    logic [hbd_pkg::ORDER_W-1:0] eff_order;
    logic [POS_W-1:0]            len_mask;
    logic [POS_W:0]              pos_inc;
    logic [POS_W-1:0]            syn_next;
    logic                        complete;
    logic [POS_W:0]              idx_inc;
    logic [POS_W:0]              idx_inc2;
    logic [POS_W:0]              idx_next;

    // order register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= hbd_pkg::ORDER_RESET;
        end else if (i_cfg_we) begin
            r_order <= i_cfg_wdata;
        end
    end

    // clamp order; length mask is 2^r - 1
    always_comb begin
        if (r_order < hbd_pkg::ORDER_MIN) begin
            eff_order = hbd_pkg::ORDER_MIN;
        end else if (r_order > ORDER_MAX) begin
            eff_order = ORDER_MAX;
        end else begin
            eff_order = r_order;
        end
        len_mask = ALL_ONES >> (ORDER_MAX - eff_order);
    end

    // incoming bit: one-based position, syndrome update, completion
    assign pos_inc  = {1'b0, r_pos} + 1'b1;
    assign syn_next = r_syn ^ (i_code_bit ? pos_inc[POS_W-1:0] : '0);
    assign complete = (pos_inc >= {1'b0, len_mask}) || i_stream_end;

    // next data index, skipping a power-of-two position
    assign idx_inc  = {1'b0, r_idx} + 1'b1;
    assign idx_inc2 = idx_inc + 1'b1;
    assign idx_next = ((idx_inc & idx_inc2) == '0) ? idx_inc2 : idx_inc;

    // collect counters: position and syndrome
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_syn <= '0;
        end else if (i_cmd.load) begin
            if (complete) begin
                r_pos <= '0;
                r_syn <= '0;
            end else begin
                r_pos <= pos_inc[POS_W-1:0];
                r_syn <= syn_next;
            end
        end
    end

    // per-word values latched at completion, data index walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && complete) begin
            r_fill   <= pos_inc[POS_W-1:0];
            r_len_m1 <= len_mask - 1'b1;
            r_flip   <= syn_next & len_mask;
            r_idx    <= FIRST_IDX;
        end else if (i_cmd.advance) begin
            r_idx <= idx_next[POS_W-1:0];
        end
    end

    // codeword store
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            mem[r_pos] <= i_code_bit;
        end
        if (i_cmd.rd_en) begin
            r_rd <= mem[r_idx];
        end
    end

    // unreceived entries read as zero; syndrome position is flipped
    assign o_data_bit   = ((r_idx < r_fill) ? r_rd : 1'b0) ^ (idx_inc == {1'b0, r_flip});
    assign o_block_last = (r_idx == r_len_m1);

    assign o_status = '{complete: complete, last: o_block_last};

endmodule
`default_nettype wire

// ===== design/hamming_block_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hamming_block_decoder
// Serial single-error-correcting Hamming decoder with configurable order.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one received code bit per transfer, in position order from
//   one; stream_end on a bit closes the codeword early, missing bits read as
//   zero. o_out carries the corrected data bits of each codeword, positions
//   that are not powers of two, with block_last on the final one.
//   i_cfg_we/i_cfg_wdata write the parity count r (2..MAX_ORDER, clamped);
//   the user writes it only while the block is idle, unenforced; reset is 3.
// Timing:
//   Bits of a codeword are taken one per cycle while collecting. After the
//   completing bit the input is held off and the store is walked, with a
//   read state and an output state for each data bit; the single-port
//   store read sets this pace. After the completing transfer the read
//   state comes first, then the first data bit is valid in the output state.
// Stall: a stalled output holds its bit; the walk waits. Input is taken
//   again the cycle after the last data bit transfers.
// Reset: synchronous, active low; clears the position counter and syndrome,
//   order returns to 3.
// ----------------------------------------------------------------------------
module hamming_block_decoder #(
    parameter int MAX_ORDER = hbd_pkg::MAX_ORDER_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [hbd_pkg::ORDER_W-1:0] i_cfg_wdata,
    hbd_in_if.sink                           i_in,
    hbd_out_if.source                        o_out
);

    hbd_pkg::t_cmd    cmd;
    hbd_pkg::t_status status;

    // sequencer
    hbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    // store and arithmetic
    hbd_dpath #(
        .MAX_ORDER (MAX_ORDER)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_cmd        (cmd),
        .i_code_bit   (i_in.code_bit),
        .i_stream_end (i_in.stream_end),
        .o_status     (status),
        .o_data_bit   (o_out.data_bit),
        .o_block_last (o_out.block_last)
    );

endmodule
`default_nettype wire

// ===== design/hbd_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hbd_port_checks
// Port-level checks on the decoder's handshake sequencing.
// ----------------------------------------------------------------------------
module hbd_port_checks (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic i_data_bit,
    input wire logic i_block_last
);

    // stalled output holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_data_bit) && $stable(i_block_last))
        else $error("output changed while stalled");

    // collecting and emitting never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready while output valid");

    // an input transfer is never followed at once by a result
    a_read_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_out_valid)
        else $error("result without store read cycle");

    // last data bit transfer returns to collecting
    a_last_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_block_last |=> i_in_ready)
        else $error("input not ready after last data bit");

    // reset leaves the block collecting
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready && !i_out_valid)
        else $error("not idle after reset");

endmodule

bind hamming_block_decoder hbd_port_checks u_hbd_port_checks (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_data_bit   (o_out.data_bit),
    .i_block_last (o_out.block_last)
);
`default_nettype wire
